// ===== rtl/tms_pkg.sv =====
package tms_pkg;

    localparam int WINDOW_TILES  = 32;
    localparam int MAX_MAP_TILES = 1024;

    localparam int CX_W    = 13;
    localparam int TILES_W = 11;
    localparam int PAGE_W  = 8;
    localparam int LEAD_W  = 5;
    localparam int SRC_W   = 21;
    localparam int DST_W   = 10;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W   = $clog2(WINDOW_TILES);

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_H  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R_LEAD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_B_LEAD  = 3'd5;

    localparam logic [TILES_W-1:0] RST_MAP_W  = 11'd128;
    localparam logic [TILES_W-1:0] RST_MAP_H  = 11'd128;
    localparam logic [PAGE_W-1:0]  RST_PAGE_W = 8'd240;
    localparam logic [PAGE_W-1:0]  RST_PAGE_H = 8'd160;
    localparam logic [LEAD_W-1:0]  RST_R_LEAD = 5'd31;
    localparam logic [LEAD_W-1:0]  RST_B_LEAD = 5'd27;

    typedef struct packed {
        logic [TILES_W-1:0] map_w;
        logic [TILES_W-1:0] map_h;
        logic [PAGE_W-1:0]  page_w;
        logic [PAGE_W-1:0]  page_h;
        logic [LEAD_W-1:0]  right_lead;
        logic [LEAD_W-1:0]  bottom_lead;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_ANALYZE,
        S_MUL_COL,
        S_SUM_COL,
        S_EMIT_COL,
        S_MUL_ROW,
        S_SUM_ROW,
        S_EMIT_ROW,
        S_NONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clamp;
        logic analyze;
        logic mul_col;
        logic mul_row;
        logic sum_col;
        logic sum_row;
        logic emit_col;
        logic emit_row;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic col_move_now;
        logic row_move_now;
        logic row_pending;
        logic step_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SRC_W-1:0]  src_index;
        logic [DST_W-1:0]  dst_index;
        logic [CX_W-1:0]   scroll_x;
        logic [CX_W-1:0]   scroll_y;
        logic              last;
    } t_result;

endpackage

// ===== rtl/tms_if.sv =====
interface tms_in_if;
    import tms_pkg::*;
    logic            valid;
    logic            ready;
    logic [CX_W-1:0] center_x;
    logic [CX_W-1:0] center_y;
    modport source (output valid, output center_x, output center_y, input ready);
    modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

interface tms_out_if;
    import tms_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  src_index;
    logic [DST_W-1:0]  dst_index;
    logic [CX_W-1:0]   scroll_x;
    logic [CX_W-1:0]   scroll_y;
    logic              last;
    modport source (output valid, output kind, output src_index, output dst_index,
                    output scroll_x, output scroll_y, output last, input ready);
    modport sink   (input valid, input kind, input src_index, input dst_index,
                    input scroll_x, input scroll_y, input last, output ready);
endinterface

interface tms_cfg_if;
    import tms_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tms_ctrl.sv =====
module tms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tms_pkg::t_status i_status,
    output logic             o_in_ready,
    output tms_pkg::t_cmd    o_cmd
);
    import tms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CLAMP;
            end
            S_CLAMP:   n_state = S_ANALYZE;
            S_ANALYZE: begin
                priority if (i_status.col_move_now) n_state = S_MUL_COL;
                else if (i_status.row_move_now)     n_state = S_MUL_ROW;
                else                                n_state = S_NONE;
            end
            S_MUL_COL: n_state = S_SUM_COL;
            S_SUM_COL: n_state = S_EMIT_COL;
            S_EMIT_COL: begin
                if (i_status.out_free && i_status.step_last) begin
                    n_state = i_status.row_pending ? S_MUL_ROW : S_IDLE;
                end
            end
            S_MUL_ROW: n_state = S_SUM_ROW;
            S_SUM_ROW: n_state = S_EMIT_ROW;
            S_EMIT_ROW: begin
                if (i_status.out_free && i_status.step_last) n_state = S_IDLE;
            end
            S_NONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_CLAMP:    o_cmd.clamp     = 1'b1;
            S_ANALYZE:  o_cmd.analyze   = 1'b1;
            S_MUL_COL:  o_cmd.mul_col   = 1'b1;
            S_SUM_COL:  o_cmd.sum_col   = 1'b1;
            S_EMIT_COL: o_cmd.emit_col  = i_status.out_free;
            S_MUL_ROW:  o_cmd.mul_row   = 1'b1;
            S_SUM_ROW:  o_cmd.sum_row   = 1'b1;
            S_EMIT_ROW: o_cmd.emit_row  = i_status.out_free;
            S_NONE:     o_cmd.emit_none = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/tms_datapath.sv =====
module tms_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tms_pkg::t_cfg               i_cfg,
    input  tms_pkg::t_cmd               i_cmd,
    input  logic [tms_pkg::CX_W-1:0]    i_center_x,
    input  logic [tms_pkg::CX_W-1:0]    i_center_y,
    input  logic                        i_out_ready,
    output tms_pkg::t_status            o_status,
    output logic                        o_out_valid,
    output tms_pkg::t_result            o_result
);
    import tms_pkg::*;

    localparam int TILE_W = CX_W - 3;

    // viewport corner, clamped to [0, map pixels - page - 1], floor of 0
    function automatic logic [CX_W-1:0] clamp_view(input logic [CX_W-1:0] c,
                                                   input logic [TILES_W-1:0] tiles,
                                                   input logic [PAGE_W-1:0] page);
        logic [TILES_W-1:0] t;
        logic signed [CX_W+1:0] v;
        logic signed [CX_W+1:0] hi;
        t  = (tiles > TILES_W'(MAX_MAP_TILES)) ? TILES_W'(MAX_MAP_TILES) : tiles;
        v  = $signed({2'b00, c}) - $signed({8'b0, page[PAGE_W-1:1]});
        hi = $signed({1'b0, t, 3'b000}) - $signed({7'b0, page});
        if (v >= hi) v = hi - 15'sd1;
        if (v < 0)   v = '0;
        return v[CX_W-1:0];
    endfunction

    logic [CX_W-1:0]    r_cx;
    logic [CX_W-1:0]    r_cy;
    logic [CX_W-1:0]    r_vx;
    logic [CX_W-1:0]    r_vy;
    logic [CX_W-1:0]    r_prev_x;
    logic [CX_W-1:0]    r_prev_y;
    logic               r_row_move;
    logic [TILES_W-1:0] r_txc;
    logic [TILES_W-1:0] r_tyr;
    logic [SRC_W-1:0]   r_prod;
    logic [SRC_W-1:0]   r_src;
    logic [WIN_W-1:0]   r_dst_row;
    logic [WIN_W-1:0]   r_dst_col;
    logic [WIN_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_result            r_out;

    logic [TILE_W-1:0]  tvx;
    logic [TILE_W-1:0]  tvy;
    logic [TILE_W-1:0]  tbx;
    logic [TILE_W-1:0]  tby;
    logic [TILES_W-1:0] pitch;
    logic [TILES_W-1:0] mul_a;
    logic [2*TILES_W-1:0] product;
    logic               out_free;

    assign tvx   = r_vx[CX_W-1:3];
    assign tvy   = r_vy[CX_W-1:3];
    assign tbx   = r_prev_x[CX_W-1:3];
    assign tby   = r_prev_y[CX_W-1:3];
    assign pitch = (i_cfg.map_w > TILES_W'(MAX_MAP_TILES)) ? TILES_W'(MAX_MAP_TILES)
                                                           : i_cfg.map_w;
    assign mul_a   = i_cmd.mul_row ? r_tyr : {1'b0, tvy};
    assign product = mul_a * pitch;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.col_move_now = (tvx != tbx);
        o_status.row_move_now = (tvy != tby);
        o_status.row_pending  = r_row_move;
        o_status.step_last    = &r_cnt;
        o_status.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_row_move  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.analyze) begin
                r_prev_x   <= r_vx;
                r_prev_y   <= r_vy;
                r_row_move <= (tvy != tby);
            end
            if (i_cmd.emit_col || i_cmd.emit_row || i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
        end
        if (i_cmd.clamp) begin
            r_vx <= clamp_view(r_cx, i_cfg.map_w, i_cfg.page_w);
            r_vy <= clamp_view(r_cy, i_cfg.map_h, i_cfg.page_h);
        end
        if (i_cmd.analyze) begin
            r_txc <= (tvx < tbx) ? {1'b0, tvx}
                                 : TILES_W'({1'b0, tvx} + TILES_W'(i_cfg.right_lead));
            r_tyr <= (tvy < tby) ? {1'b0, tvy}
                                 : TILES_W'({1'b0, tvy} + TILES_W'(i_cfg.bottom_lead));
        end
        if (i_cmd.mul_col || i_cmd.mul_row) begin
            r_prod <= product[SRC_W-1:0];
        end
        if (i_cmd.sum_col) begin
            r_src     <= r_prod + SRC_W'(r_txc);
            r_dst_row <= tvy[WIN_W-1:0];
            r_dst_col <= r_txc[WIN_W-1:0];
            r_cnt     <= '0;
        end
        if (i_cmd.sum_row) begin
            r_src     <= r_prod + SRC_W'(tvx);
            r_dst_row <= r_tyr[WIN_W-1:0];
            r_dst_col <= tvx[WIN_W-1:0];
            r_cnt     <= '0;
        end
        // column walks down the source by one pitch a beat
        if (i_cmd.emit_col) begin
            r_out.kind      <= KIND_COL;
            r_out.src_index <= r_src;
            r_out.dst_index <= {r_dst_row, r_dst_col};
            r_out.last      <= (&r_cnt) && !r_row_move;
            r_src           <= r_src + SRC_W'(pitch);
            r_dst_row       <= r_dst_row + WIN_W'(1);
            r_cnt           <= r_cnt + WIN_W'(1);
        end
        if (i_cmd.emit_row) begin
            r_out.kind      <= KIND_ROW;
            r_out.src_index <= r_src;
            r_out.dst_index <= {r_dst_row, r_dst_col};
            r_out.last      <= &r_cnt;
            r_src           <= r_src + SRC_W'(1);
            r_dst_col       <= r_dst_col + WIN_W'(1);
            r_cnt           <= r_cnt + WIN_W'(1);
        end
        if (i_cmd.emit_none) begin
            r_out.kind      <= KIND_NONE;
            r_out.src_index <= '0;
            r_out.dst_index <= '0;
            r_out.last      <= 1'b1;
        end
        if (i_cmd.emit_col || i_cmd.emit_row || i_cmd.emit_none) begin
            r_out.scroll_x <= r_vx;
            r_out.scroll_y <= r_vy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== rtl/tile_map_scroll_streamer_core.sv =====
// Tile-map scroll streamer. One input beat per frame carries the camera center
// in map pixels; the block clamps the viewport, compares its tile position with
// the previous frame and streams copy pairs into a 32x32 wrapping screen map:
// 32 column pairs if the tile column changed, then 32 row pairs if the tile row
// changed, or a single offset-only beat if neither moved. Every beat carries
// the frame's scroll offsets and the final one has last set. From accept a frame
// goes through clamp and compare; each copy then has a multiply and a sum setup
// step, using the shared 11x11 multiplier to form its first source index, after
// which the output register issues one beat a cycle while the output is not
// stalled. The next frame is accepted while the last beat still waits in the
// output register. Configuration goes through the register port and is meant
// to be written only while no frame is in flight; unknown indexes are ignored.
module tile_map_scroll_streamer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tms_in_if.sink    i_in,
    tms_out_if.source o_out,
    tms_cfg_if.sink   i_cfg
);
    import tms_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    out_valid;
    logic    in_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_w       <= RST_MAP_W;
            r_cfg.map_h       <= RST_MAP_H;
            r_cfg.page_w      <= RST_PAGE_W;
            r_cfg.page_h      <= RST_PAGE_H;
            r_cfg.right_lead  <= RST_R_LEAD;
            r_cfg.bottom_lead <= RST_B_LEAD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAP_W:  r_cfg.map_w       <= i_cfg.data[TILES_W-1:0];
                CFG_MAP_H:  r_cfg.map_h       <= i_cfg.data[TILES_W-1:0];
                CFG_PAGE_W: r_cfg.page_w      <= i_cfg.data[PAGE_W-1:0];
                CFG_PAGE_H: r_cfg.page_h      <= i_cfg.data[PAGE_W-1:0];
                CFG_R_LEAD: r_cfg.right_lead  <= i_cfg.data[LEAD_W-1:0];
                CFG_B_LEAD: r_cfg.bottom_lead <= i_cfg.data[LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    tms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tms_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_center_x  (i_in.center_x),
        .i_center_y  (i_in.center_y),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign i_in.ready      = in_ready;
    assign o_out.valid     = out_valid;
    assign o_out.kind      = result.kind;
    assign o_out.src_index = result.src_index;
    assign o_out.dst_index = result.dst_index;
    assign o_out.scroll_x  = result.scroll_x;
    assign o_out.scroll_y  = result.scroll_y;
    assign o_out.last      = result.last;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted twice in a row");

    a_none_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.kind == KIND_NONE |->
            o_out.last && o_out.src_index == '0 && o_out.dst_index == '0)
        else $error("offset-only beat malformed");

    a_mid_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last |-> !i_in.ready)
        else $error("input ready while frame still streaming");
`endif

endmodule
